// ----- hw/rtl/ctpr_pkg.sv -----
// Package for the 5x7 character-to-pixel-square generator.
// Holds shared widths, register map, reset values, control structs and the glyph ROM.
// No dependencies.
`default_nettype none

package ctpr_pkg;

   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
   localparam int COL_W      = $clog2(GLYPH_COLS);

   localparam int CODE_W  = 8;
   localparam int IDX_W   = 8;
   localparam int ORG_W   = 20;
   localparam int SIZE_W  = 12;
   localparam int SPACE_W = 12;
   localparam int POS_W   = 32;

   // pitch = 5*size + spacing; product = index * pitch; x and y accumulators
   localparam int PITCH_W = 17;
   localparam int PROD_W  = IDX_W + 1 + PITCH_W;
   localparam int X_W     = PROD_W + 1;
   localparam int Y_W     = ORG_W + 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
   localparam logic [1:0] REG_PIXEL_SIZE    = 2'd2;
   localparam logic [1:0] REG_GLYPH_SPACING = 2'd3;

   localparam logic [SIZE_W-1:0] PIXEL_SIZE_RESET = 12'd16;

   typedef struct packed {
      logic signed [ORG_W-1:0]   origin_x;
      logic signed [ORG_W-1:0]   origin_y;
      logic        [SIZE_W-1:0]  pixel_size;
      logic signed [SPACE_W-1:0] glyph_spacing;
   } ctpr_cfg_type;

   typedef struct packed {
      logic load;   // take a request, latch glyph and index product
      logic base;   // set up the scan origin
      logic step;   // advance one pixel
   } ctpr_cmd_type;

   typedef struct packed {
      logic done;      // no lit pixel left
      logic cur_lit;   // pixel under the scan is lit
      logic out_free;  // output register can take a square this cycle
   } ctpr_stat_type;

   // Row 0 in the top bits, leftmost column first; unknown codes are blank.
   function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
      logic [GLYPH_BITS-1:0] g;
      case (code)
         8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
         8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
         8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
         8'h33: g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E}; // 3
         8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
         8'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E}; // 5
         8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
         8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
         8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
         8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}; // 9
         8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
         8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
         8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E}; // G
         8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // I
         8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
         8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
         8'h4E: g = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11}; // N
         8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
         8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
         8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}; // Q
         8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
         8'h53: g = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E}; // S
         8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
         8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
         8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04}; // V
         8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
         default: g = '0;  // space and every unknown code
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ctpr_req_if.sv -----
// Request channel: one character code per request.
// Depends on ctpr_pkg.
`default_nettype none

interface ctpr_req_if import ctpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ctpr_rsp_if.sv -----
// Response channel: one pixel square per transfer.
// Depends on ctpr_pkg.
`default_nettype none

interface ctpr_rsp_if import ctpr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  square_x;
   logic signed [POS_W-1:0]  square_y;
   logic        [SIZE_W-1:0] square_side;
   logic                     last_square;

   modport source (output valid, output square_x, output square_y, output square_side,
                   output last_square, input ready);
   modport sink   (input valid, input square_x, input square_y, input square_side,
                   input last_square, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/char_to_pixel_rects_top.sv -----
// Top level of the 5x7 character-to-pixel-square generator.
// Depends on ctpr_pkg, ctpr_req_if, ctpr_rsp_if, ctpr_csr, ctpr_ctrl, ctpr_dp.
//
// Usage:
//   req_ch carries one character code per request (valid/ready); end_of_text
//   marks the final character and clears the kept character index afterwards.
//   rsp_ch returns one square per lit glyph pixel, row by row from the top,
//   left to right, with last_square on the final one. Blank or unknown codes
//   and a pixel size of zero return nothing but still advance the index.
//   The APB port sets origin_x (0x0), origin_y (0x4), pixel_size (0x8) and
//   glyph_spacing (0xC); write only while no request is in flight.
// Timing:
//   One request at a time. The accepting edge forms index*pitch, the next one
//   sets the scan origin, then the scan walks the 35 glyph pixels at one per
//   cycle unless a lit pixel waits for output room, stopping after the last
//   lit one. A stalled response holds the scan on the next lit pixel only;
//   the next request is taken while the final square still waits.
// Reset (synchronous, active high) clears the index, the scan and the output
// register, and loads the register defaults (pixel size 16, others zero).
`default_nettype none

module char_to_pixel_rects_top import ctpr_pkg::*; #(
   parameter int MAX_TEXT_LENGTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ctpr_req_if.sink                   req_ch,
   ctpr_rsp_if.source                 rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   ctpr_cfg_type  cfg;
   ctpr_cmd_type  cmd;
   ctpr_stat_type stat;

   ctpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ctpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ctpr_dp #(
      .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .stat        (stat),
      .char_code   (req_ch.char_code),
      .end_of_text (req_ch.end_of_text),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .square_x    (rsp_ch.square_x),
      .square_y    (rsp_ch.square_y),
      .square_side (rsp_ch.square_side),
      .last_square (rsp_ch.last_square)
   );

`ifndef SYNTH
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while previous one still in setup");
   a_rsp_only_after_setup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> !req_ch.ready)
      else $error("square produced outside a scan");
   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("configuration port not ready");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ctpr_csr.sv -----
// APB-style configuration registers: origin, pixel size, glyph spacing.
// Depends on ctpr_pkg.
`default_nettype none

module ctpr_csr import ctpr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      ctpr_cfg_type          cfg
);

   ctpr_cfg_type cfg_ff, cfg_in;
   logic         wr_en;
   logic [1:0]   reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ORIGIN_X:      cfg_in.origin_x      = pwdata[ORG_W-1:0];
            REG_ORIGIN_Y:      cfg_in.origin_y      = pwdata[ORG_W-1:0];
            REG_PIXEL_SIZE:    cfg_in.pixel_size    = pwdata[SIZE_W-1:0];
            REG_GLYPH_SPACING: cfg_in.glyph_spacing = pwdata[SPACE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ORIGIN_X:      prdata = {{(CSR_DATA_W-ORG_W){1'b0}}, cfg_ff.origin_x};
         REG_ORIGIN_Y:      prdata = {{(CSR_DATA_W-ORG_W){1'b0}}, cfg_ff.origin_y};
         REG_PIXEL_SIZE:    prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cfg_ff.pixel_size};
         REG_GLYPH_SPACING: prdata = {{(CSR_DATA_W-SPACE_W){1'b0}}, cfg_ff.glyph_spacing};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.pixel_size    <= PIXEL_SIZE_RESET;
         cfg_ff.glyph_spacing <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ctpr_ctrl.sv -----
// Controller: sequences load, setup and pixel scan for one request at a time.
// Depends on ctpr_pkg.
`default_nettype none

module ctpr_ctrl import ctpr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire ctpr_stat_type stat,
   output      ctpr_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BASE = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.done) begin
               state_in = ST_IDLE;
            end else begin
               // a lit pixel waits for room in the output register
               cmd.step = !stat.cur_lit || stat.out_free;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE)
      else $error("load issued outside idle");
   a_base_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.base)
      else $error("setup did not follow load");
   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.step && stat.cur_lit |-> stat.out_free)
      else $error("lit pixel stepped without output room");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ctpr_dp.sv -----
// Datapath: glyph shift register, character index, position accumulators, output register.
// Depends on ctpr_pkg.
`default_nettype none

module ctpr_dp import ctpr_pkg::*; #(
   parameter int MAX_TEXT_LENGTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctpr_cfg_type             cfg,
   input  wire ctpr_cmd_type             cmd,
   output      ctpr_stat_type            stat,
   input  wire logic [CODE_W-1:0]        char_code,
   input  wire logic                     end_of_text,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [POS_W-1:0]  square_x,
   output      logic signed [POS_W-1:0]  square_y,
   output      logic        [SIZE_W-1:0] square_side,
   output      logic                     last_square
);

   logic        [IDX_W-1:0]      idx_ff, idx_in;
   logic        [IDX_W:0]        idx_next;
   logic        [GLYPH_BITS-1:0] glyph_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [PITCH_W-1:0]    pitch;
   logic signed [X_W-1:0]        left_ff, left_in, x_ff;
   logic signed [Y_W-1:0]        y_ff;
   logic        [COL_W-1:0]      col_ff;
   logic                         out_valid_ff, out_load, last_in;
   logic signed [X_W-1:0]        out_x_ff;
   logic signed [Y_W-1:0]        out_y_ff;
   logic        [SIZE_W-1:0]     out_side_ff;
   logic                         out_last_ff;

   assign pitch = $signed({3'b000, cfg.pixel_size, 2'b00})
                + $signed({5'b00000, cfg.pixel_size})
                + $signed({{(PITCH_W-SPACE_W){cfg.glyph_spacing[SPACE_W-1]}},
                           cfg.glyph_spacing});

   assign left_in = $signed({{(X_W-ORG_W){cfg.origin_x[ORG_W-1]}}, cfg.origin_x})
                  + $signed({prod_ff[PROD_W-1], prod_ff});

   // index advance, wrapping at the text length, at its own width and on end of text
   assign idx_next = {1'b0, idx_ff} + {{IDX_W{1'b0}}, 1'b1};
   always_comb begin
      if (end_of_text || (32'(idx_next) >= 32'(MAX_TEXT_LENGTH))) begin
         idx_in = '0;
      end else begin
         idx_in = idx_next[IDX_W-1:0];
      end
   end

   assign stat.done     = (glyph_ff == '0);
   assign stat.cur_lit  = glyph_ff[GLYPH_BITS-1];
   assign stat.out_free = !out_valid_ff || rsp_ready;

   assign out_load = cmd.step && glyph_ff[GLYPH_BITS-1];
   assign last_in  = (glyph_ff[GLYPH_BITS-2:0] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         glyph_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= idx_in;
            // zero pixel size draws nothing
            glyph_ff <= (cfg.pixel_size == '0) ? '0 : glyph_lookup(char_code);
         end else if (cmd.step) begin
            glyph_ff <= {glyph_ff[GLYPH_BITS-2:0], 1'b0};
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_ff <= PROD_W'($signed({1'b0, idx_ff})) * PROD_W'(pitch);
      end
      if (cmd.base) begin
         left_ff <= left_in;
         x_ff    <= left_in;
         y_ff    <= $signed({{(Y_W-ORG_W){cfg.origin_y[ORG_W-1]}}, cfg.origin_y});
         col_ff  <= '0;
      end else if (cmd.step) begin
         if (col_ff == COL_W'(GLYPH_COLS - 1)) begin
            col_ff <= '0;
            x_ff   <= left_ff;
            y_ff   <= y_ff + $signed({{(Y_W-SIZE_W){1'b0}}, cfg.pixel_size});
         end else begin
            col_ff <= col_ff + COL_W'(1);
            x_ff   <= x_ff + $signed({{(X_W-SIZE_W){1'b0}}, cfg.pixel_size});
         end
      end
      if (out_load) begin
         out_x_ff    <= x_ff;
         out_y_ff    <= y_ff;
         out_side_ff <= cfg.pixel_size;
         out_last_ff <= last_in;
      end
   end

   // accumulators never leave the 32-bit range, so sign extension is exact
   assign rsp_valid   = out_valid_ff;
   assign square_x    = {{(POS_W-X_W){out_x_ff[X_W-1]}}, out_x_ff};
   assign square_y    = {{(POS_W-Y_W){out_y_ff[Y_W-1]}}, out_y_ff};
   assign square_side = out_side_ff;
   assign last_square = out_last_ff;

`ifndef SYNTH
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !$isunknown(out_last_ff) && 32'(col_ff) < GLYPH_COLS)
      else $error("column counter out of range");
   a_last_empties_glyph: assert property (@(posedge clock) disable iff (reset)
      out_load && last_in |=> glyph_ff == '0)
      else $error("last square flagged with pixels left");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !out_valid_ff || rsp_ready)
      else $error("pending square overwritten");
`endif

endmodule

`default_nettype wire
